FILE: rtl/fbpc_pkg.sv
// ----------------------------------------------------------------------------
// fbpc_pkg
// Shared types and constants for the four-button press classifier.
// ----------------------------------------------------------------------------
package fbpc_pkg;

    localparam int NOW_W    = 32;
    localparam int THRESH_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [THRESH_W-1:0]  thresh_t;
    typedef logic [NOW_W-1:0]     now_ms_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_HOLD_MS = 2'd0,
        CFG_HOLD_MS      = 2'd1,
        CFG_SHORT_MIN_MS = 2'd2
    } cfg_idx_t;

    localparam thresh_t LONG_HOLD_MS_RST = 16'd1000;
    localparam thresh_t HOLD_MS_RST      = 16'd500;
    localparam thresh_t SHORT_MIN_MS_RST = 16'd50;

    // live threshold set
    typedef struct packed {
        thresh_t long_hold_ms;
        thresh_t hold_ms;
        thresh_t short_min_ms;
    } cfg_t;

    // one result beat
    typedef struct packed {
        logic a_short;
        logic a_long;
        logic b_hold;
        logic b_short;
        logic c_hold;
        logic d_hold;
        logic d_short;
    } events_t;

    // one button's outcome for a poll
    typedef struct packed {
        logic hold_ev;
        logic short_ev;
    } btn_ev_t;

endpackage

FILE: rtl/fbpc_ifs.sv
// ----------------------------------------------------------------------------
// fbpc interfaces
// Valid/ready channels for poll beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface fbpc_poll_if
    import fbpc_pkg::*;
();
    logic    valid;
    logic    ready;
    now_ms_t now_ms;
    logic    level_a;
    logic    level_b;
    logic    level_c;
    logic    level_d;

    modport source (output valid, now_ms, level_a, level_b, level_c, level_d,
                    input ready);
    modport sink   (input valid, now_ms, level_a, level_b, level_c, level_d,
                    output ready);
endinterface

interface fbpc_result_if;
    logic valid;
    logic ready;
    logic a_short;
    logic a_long;
    logic b_hold;
    logic b_short;
    logic c_hold;
    logic d_hold;
    logic d_short;

    modport source (output valid, a_short, a_long, b_hold, b_short, c_hold,
                    d_hold, d_short, input ready);
    modport sink   (input valid, a_short, a_long, b_hold, b_short, c_hold,
                    d_hold, d_short, output ready);
endinterface

interface fbpc_cfg_if
    import fbpc_pkg::*;
();
    logic       valid;
    logic       ready;
    cfg_index_t index;
    thresh_t    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/fbpc_cfg.sv
// ----------------------------------------------------------------------------
// fbpc_cfg
// Threshold registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module fbpc_cfg
    import fbpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fbpc_cfg_if.sink   cfg,
    output cfg_t       thresholds
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready  = 1'b1;
    assign thresholds = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LONG_HOLD_MS: cfg_next.long_hold_ms = cfg.data;
                CFG_HOLD_MS:      cfg_next.hold_ms      = cfg.data;
                CFG_SHORT_MIN_MS: cfg_next.short_min_ms = cfg.data;
                default:          cfg_next = cfg_reg; // unmapped: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_hold_ms <= LONG_HOLD_MS_RST;
            cfg_reg.hold_ms      <= HOLD_MS_RST;
            cfg_reg.short_min_ms <= SHORT_MIN_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/fbpc_button.sv
// ----------------------------------------------------------------------------
// fbpc_button
// Press tracker for one button: stamp, hold flag, hold and short events.
// ----------------------------------------------------------------------------
module fbpc_button
    import fbpc_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,      // poll beat leaves the input stage
    input  logic [TIME_BITS-1:0] now,
    input  logic                 level,     // active low
    input  thresh_t              thresh,
    input  thresh_t              short_lo,  // short window, exclusive bounds
    input  thresh_t              short_hi,
    output btn_ev_t              ev
);

    logic [TIME_BITS-1:0] stamp_reg;
    logic [TIME_BITS-1:0] stamp_next;
    logic                 seen_reg;
    logic                 seen_next;
    logic [TIME_BITS-1:0] held;

    assign held = now - stamp_reg;   // wraps at TIME_BITS

    always_comb
    begin
        stamp_next  = stamp_reg;
        seen_next   = seen_reg;
        ev.hold_ev  = 1'b0;
        ev.short_ev = 1'b0;
        if (!level)
        begin
            if (stamp_reg == '0)
            begin
                stamp_next = now;
            end
            else if (held > TIME_BITS'(thresh) && !seen_reg)
            begin
                seen_next  = 1'b1;
                ev.hold_ev = 1'b1;
            end
        end
        else if (stamp_reg != '0)
        begin
            ev.short_ev = !seen_reg && (held > TIME_BITS'(short_lo))
                          && (held < TIME_BITS'(short_hi));
            stamp_next  = '0;
            seen_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (step)
        begin
            stamp_reg <= stamp_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

FILE: rtl/four_button_press_classifier.sv
// ----------------------------------------------------------------------------
// four_button_press_classifier
// Classifies polls of four active-low buttons into hold, long and short
// press events against three programmable millisecond thresholds.
// ----------------------------------------------------------------------------
//
//  channel   dir   beat carries                          when taken
//  poll      in    now_ms, level_a..level_d              valid & ready
//  result    out   a_short a_long b_hold b_short         valid & ready
//                  c_hold d_hold d_short
//  cfg       in    index (0..2), data (16 bits)          valid & ready
//
//  One poll per cycle sustained while result.ready is high; each poll
//  passes through the input register, then the result register, before
//  its result beat is offered.
//  The button state updates as a poll moves from the input register into
//  the result register, so each poll sees everything before it.
//  A stalled result holds the pipe; poll.ready falls only when both the
//  input and result registers are full and result.ready is low.
//  Reset gives idle buttons and thresholds 1000 / 500 / 50 ms; cfg is
//  always ready.
// ----------------------------------------------------------------------------
module four_button_press_classifier
    import fbpc_pkg::*;
#(
    parameter int TIME_BITS = 32   // held-time wrap width, 16..64
)
(
    input  logic          clk,
    input  logic          rst_n,
    fbpc_poll_if.sink     poll,
    fbpc_result_if.source result,
    fbpc_cfg_if.sink      cfg
);

    // -- thresholds --------------------------------------------------------
    cfg_t thr;

    fbpc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .thresholds (thr)
    );

    // -- input register ----------------------------------------------------
    logic    in_valid_reg;
    logic    in_valid_next;
    now_ms_t now_reg;
    logic    lvl_a_reg;
    logic    lvl_b_reg;
    logic    lvl_c_reg;
    logic    lvl_d_reg;

    // -- result register ---------------------------------------------------
    logic    out_valid_reg;
    logic    out_valid_next;
    events_t out_reg;
    events_t out_next;

    logic poll_take;   // poll beat accepted
    logic advance;     // input stage moves into the result register
    logic out_room;

    assign out_room    = !out_valid_reg || result.ready;
    assign advance     = in_valid_reg && out_room;
    assign poll.ready  = !in_valid_reg || out_room;
    assign poll_take   = poll.valid && poll.ready;

    assign in_valid_next  = poll_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            now_reg   <= poll.now_ms;
            lvl_a_reg <= poll.level_a;
            lvl_b_reg <= poll.level_b;
            lvl_c_reg <= poll.level_c;
            lvl_d_reg <= poll.level_d;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // -- button trackers ---------------------------------------------------
    // Time is cut to (or zero-extended to) the wrap width.
    logic [TIME_BITS-1:0] now_t;
    thresh_t              a_short_hi;
    btn_ev_t              ev_a;
    btn_ev_t              ev_b;
    btn_ev_t              ev_c;
    btn_ev_t              ev_d;

    assign now_t      = TIME_BITS'(now_reg);
    assign a_short_hi = thr.long_hold_ms >> 1;   // half the long threshold

    // A: long press past long_hold_ms; short between hold_ms and long/2
    fbpc_button #(.TIME_BITS(TIME_BITS)) u_btn_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .now      (now_t),
        .level    (lvl_a_reg),
        .thresh   (thr.long_hold_ms),
        .short_lo (thr.hold_ms),
        .short_hi (a_short_hi),
        .ev       (ev_a)
    );

    // B: hold past hold_ms; short between short_min_ms and hold_ms
    fbpc_button #(.TIME_BITS(TIME_BITS)) u_btn_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .now      (now_t),
        .level    (lvl_b_reg),
        .thresh   (thr.hold_ms),
        .short_lo (thr.short_min_ms),
        .short_hi (thr.hold_ms),
        .ev       (ev_b)
    );

    // C: hold only; an empty window never yields a short press
    fbpc_button #(.TIME_BITS(TIME_BITS)) u_btn_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .now      (now_t),
        .level    (lvl_c_reg),
        .thresh   (thr.hold_ms),
        .short_lo ('0),
        .short_hi ('0),
        .ev       (ev_c)
    );

    // D: same as B
    fbpc_button #(.TIME_BITS(TIME_BITS)) u_btn_d (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .now      (now_t),
        .level    (lvl_d_reg),
        .thresh   (thr.hold_ms),
        .short_lo (thr.short_min_ms),
        .short_hi (thr.hold_ms),
        .ev       (ev_d)
    );

    always_comb
    begin
        out_next.a_short = ev_a.short_ev;
        out_next.a_long  = ev_a.hold_ev;
        out_next.b_hold  = ev_b.hold_ev;
        out_next.b_short = ev_b.short_ev;
        out_next.c_hold  = ev_c.hold_ev;
        out_next.d_hold  = ev_d.hold_ev;
        out_next.d_short = ev_d.short_ev;
    end

    // -- result channel ----------------------------------------------------
    assign result.valid   = out_valid_reg;
    assign result.a_short = out_reg.a_short;
    assign result.a_long  = out_reg.a_long;
    assign result.b_hold  = out_reg.b_hold;
    assign result.b_short = out_reg.b_short;
    assign result.c_hold  = out_reg.c_hold;
    assign result.d_hold  = out_reg.d_hold;
    assign result.d_short = out_reg.d_short;

endmodule
